>>> rtl/core/b64d_pkg.sv
// b64d_pkg: shared types, constants and helper functions for the base64 stream decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package b64d_pkg;

   // decode job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   // one decode job: up to three bytes, a bare end marker when byte_count is zero
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] byte_count;
      logic       end_str;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.hit   = 1'b1;
      s.value = 6'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         s.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.value = SEXTET_SLASH;
      end else begin
         s.hit = 1'b0;
      end
      return s;
   endfunction

   function automatic logic [7:0] pack_byte0(input logic [5:0] a, input logic [5:0] b);
      return {a, b[5:4]};
   endfunction

   function automatic logic [7:0] pack_byte1(input logic [5:0] b, input logic [5:0] c);
      return {b[3:0], c[5:2]};
   endfunction

   function automatic logic [7:0] pack_byte2(input logic [5:0] c, input logic [5:0] d);
      return {c[1:0], d};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/base64_stream_decoder_top.sv
// base64_stream_decoder_top: streaming base64 decoder, standard alphabet
// depends on b64d_pkg, b64d_front, b64d_queue and b64d_back
//
// usage
//   req channel: one raw character per item with req_end_of_string on the
//   last character of a string. rsp channel: zero to three result items per
//   request item, each one decoded byte or a bare end marker; rsp_run_last
//   flags the last item of a request, rsp_string_done the last of a string.
//   both channels hand over an item on a rising edge with valid high and
//   stall low.
//   the first result of a request passes a job queue entry, then the
//   output register, before it is on rsp. the front takes one character
//   per cycle while the queue is not full; the back sends one result per
//   cycle from its output register while rsp is not stalled, so a full
//   group (three results per four characters) keeps pace with a character a cycle.
//   a four-entry job queue between front and back sets how far the front can
//   run ahead; req_stall rises only when that queue is full.
//   when rsp is stalled the output register holds its item and the queue
//   fills; characters without results still enter until it is full.
//   reset clears the sextet group, the halt flag, the queue and rsp_valid.
`default_nettype none

module base64_stream_decoder_top
   import b64d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_encoded_char,
   input  wire logic       req_end_of_string,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_string_done,
   output logic            rsp_run_last
);

   q_status_type q_status;
   job_type      push_job;
   job_type      head_job;
   logic         push;
   logic         pop;

   b64d_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_encoded_char  (req_encoded_char),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .push              (push),
      .push_job          (push_job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

`default_nettype wire

>>> rtl/core/b64d_front.sv
// b64d_front: accepts characters, maps them to sextets and builds decode jobs
// depends on b64d_pkg; pushes jobs into b64d_queue
`default_nettype none

module b64d_front
   import b64d_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_encoded_char,
   input  wire logic         req_end_of_string,
   input  wire q_status_type q_status,
   output logic              push,
   output job_type           push_job
);

   logic [5:0] store_ff [3];
   logic [5:0] store_in [3];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       halted_ff;
   logic       halted_in;
   logic       accept;
   sextet_type sx;
   job_type    job;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      sx        = sextet_of(req_encoded_char);
      store_in  = store_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      job       = '0;

      if (!halted_ff) begin
         if (sx.hit) begin
            if (count_ff == 2'd3) begin
               job.byte0      = pack_byte0(store_ff[0], store_ff[1]);
               job.byte1      = pack_byte1(store_ff[1], store_ff[2]);
               job.byte2      = pack_byte2(store_ff[2], sx.value);
               job.byte_count = 2'd3;
               count_in       = 2'd0;
            end else begin
               store_in[count_ff] = sx.value;
               count_in           = count_ff + 2'd1;
            end
         end else begin
            halted_in = 1'b1;
         end

         // partial flush
         if (halted_in || req_end_of_string) begin
            if (count_in == 2'd2) begin
               job.byte0      = pack_byte0(store_in[0], store_in[1]);
               job.byte_count = 2'd1;
            end else if (count_in == 2'd3) begin
               job.byte0      = pack_byte0(store_in[0], store_in[1]);
               job.byte1      = pack_byte1(store_in[1], store_in[2]);
               job.byte_count = 2'd2;
            end
            count_in = 2'd0;
         end
      end

      job.end_str = req_end_of_string;

      // restart for the next string
      if (req_end_of_string) begin
         store_in[0] = 6'd0;
         store_in[1] = 6'd0;
         store_in[2] = 6'd0;
         count_in    = 2'd0;
         halted_in   = 1'b0;
      end
   end

   assign push     = accept && (job.byte_count != 2'd0 || req_end_of_string);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff[0] <= 6'd0;
         store_ff[1] <= 6'd0;
         store_ff[2] <= 6'd0;
         count_ff    <= 2'd0;
         halted_ff   <= 1'b0;
      end else if (accept) begin
         store_ff  <= store_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/b64d_queue.sv
// b64d_queue: short job queue that decouples the front from the back
// depends on b64d_pkg; written by b64d_front, drained by b64d_back
`default_nettype none

module b64d_queue
   import b64d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output q_status_type q_status
);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_W'(1);
   endfunction

   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QUEUE_CNT_W'(1);
            2'b01:   count_ff <= count_ff - QUEUE_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job popped from empty queue");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

>>> rtl/core/b64d_back.sv
// b64d_back: unrolls each decode job into result items, one per cycle unless stalled
// depends on b64d_pkg; drains b64d_queue into the output register
`default_nettype none

module b64d_back
   import b64d_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire job_type      head_job,
   input  wire q_status_type q_status,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_string_done,
   output logic              rsp_run_last
);

   logic [1:0] idx_ff;
   logic       rsp_valid_ff;
   logic [7:0] data_byte_ff;
   logic       byte_valid_ff;
   logic       string_done_ff;
   logic       run_last_ff;
   logic       load;
   logic       take;
   logic [1:0] last_idx;
   logic       is_last;
   logic [7:0] sel_byte;

   assign load     = !rsp_valid_ff || !rsp_stall;
   assign take     = load && !q_status.empty;
   assign last_idx = (head_job.byte_count == 2'd0) ? 2'd0 : head_job.byte_count - 2'd1;
   assign is_last  = (idx_ff == last_idx);
   assign pop      = take && is_last;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head_job.byte0;
         2'd1:    sel_byte = head_job.byte1;
         2'd2:    sel_byte = head_job.byte2;
         default: sel_byte = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !q_status.empty;
         end
         if (take) begin
            idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_byte_ff   <= (head_job.byte_count == 2'd0) ? 8'd0 : sel_byte;
         byte_valid_ff  <= (head_job.byte_count != 2'd0);
         string_done_ff <= is_last && head_job.end_str;
         run_last_ff    <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_byte   = data_byte_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_string_done = string_done_ff;
   assign rsp_run_last    = run_last_ff;

   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (idx_ff <= last_idx))
      else $error("result index past end of job");

   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_string_done) |-> rsp_run_last)
      else $error("string end on non-final item of a job");

   a_marker_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_byte_valid) |-> (rsp_string_done && rsp_data_byte == 8'd0))
      else $error("bare marker without string end or with data");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench: self-checking bench for base64_stream_decoder_top, a table of directed items
// then random encoded strings, each result checked against typed rows or an in-bench decoder model
// depends on b64d_pkg and the decoder rtl only
`timescale 1ns / 1ps

module testbench;
   import b64d_pkg::*;

   localparam logic [7:0] CHAR_PAD = 8'h3d;
   localparam int DIRECTED_ROWS = 26;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0]  ch;
      logic        eos;
      logic        typed;
      logic [1:0]  n_bytes;
      logic [23:0] bytes;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_ok;
      logic       done;
      logic       last;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_encoded_char = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_string_done;
   logic       rsp_run_last;

   // decoder model state
   logic [5:0] held_sextets [3];
   logic [1:0] held_count = 2'd0;
   logic       decode_halted = 1'b0;

   decoded_type  expected_decoded [$];
   stim_row_type directed_rows [DIRECTED_ROWS];
   int           send_idle_pct = 11;
   int           recv_idle_pct = 65;
   int           chars_sent = 0;
   int           mismatches = 0;
   bit           hold_request = 1'b0;

   base64_stream_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_encoded_char  (req_encoded_char),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_string_done   (rsp_string_done),
      .rsp_run_last      (rsp_run_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void append_expected(input decoded_type d);
      expected_decoded.insert(expected_decoded.size(), d);
   endfunction

   // returns how many bytes one character releases; the bytes go out in out_bytes, first byte in the top bits
   function automatic int decode_char(input logic [7:0] ch, input logic eos,
                                      output logic [23:0] out_bytes);
      logic [5:0] v;
      logic       hit;
      int         n;
      n = 0;
      v = 6'd0;
      hit = 1'b1;
      out_bytes = 24'h0;
      if (!decode_halted) begin
         if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            v = 6'(ch - CHAR_UPPER_A);
         end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            v = 6'(ch - CHAR_LOWER_A + 8'd26);
         end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            v = 6'(ch - CHAR_DIGIT_0 + 8'd52);
         end else if (ch == CHAR_PLUS) begin
            v = 6'd62;
         end else if (ch == CHAR_SLASH) begin
            v = 6'd63;
         end else begin
            hit = 1'b0;
         end
         if (!hit) begin
            decode_halted = 1'b1;
         end else if (held_count == 2'd3) begin
            out_bytes = {held_sextets[0], held_sextets[1], held_sextets[2], v};
            n = 3;
            held_count = 2'd0;
         end else begin
            held_sextets[held_count] = v;
            held_count = held_count + 2'd1;
         end
         // partial group flush
         if (decode_halted || eos) begin
            if (held_count >= 2'd2) begin
               out_bytes[23:16] = {held_sextets[0], held_sextets[1][5:4]};
               n = 1;
            end
            if (held_count == 2'd3) begin
               out_bytes[15:8] = {held_sextets[1][3:0], held_sextets[2][5:2]};
               n = 2;
            end
            held_count = 2'd0;
         end
      end
      if (eos) begin
         held_sextets = '{default: 6'd0};
         held_count = 2'd0;
         decode_halted = 1'b0;
      end
      return n;
   endfunction

   function automatic logic [7:0] alphabet_char();
      int v;
      v = $urandom_range(63);
      if (v < 26) return CHAR_UPPER_A + 8'(v);
      if (v < 52) return CHAR_LOWER_A + 8'(v - 26);
      if (v < 62) return CHAR_DIGIT_0 + 8'(v - 52);
      if (v == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic eos, input logic typed,
                            input logic [1:0] n_typed, input logic [23:0] typed_bytes);
      logic [23:0] out_bytes;
      int          n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_encoded_char <= ch;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      n = decode_char(ch, eos, out_bytes);
      if (typed) begin
         n = int'(n_typed);
         out_bytes = typed_bytes;
      end
      if (eos && n == 0) begin
         append_expected('{8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
         for (int i = 0; i < n; i++) begin
            append_expected('{out_bytes[23 - 8 * i -: 8], 1'b1,
                              eos && (i == n - 1), i == n - 1});
         end
      end
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_string();
      logic [7:0] text [$];
      int         kind;
      int         groups;
      int         tail;
      kind = $urandom_range(9);
      if (kind < 8) begin
         groups = $urandom_range(3);
         tail = $urandom_range(3);
         if (groups == 0 && tail == 0) groups = 1;
         repeat (groups * 4) text.insert(text.size(), alphabet_char());
         case (tail)
            1: begin
               repeat (2) text.insert(text.size(), alphabet_char());
               repeat (2) text.insert(text.size(), CHAR_PAD);
            end
            2: begin
               repeat (3) text.insert(text.size(), alphabet_char());
               text.insert(text.size(), CHAR_PAD);
            end
            3: begin
               repeat ($urandom_range(1, 3)) text.insert(text.size(), alphabet_char());
            end
            default: ;
         endcase
         // broken string: one character replaced by any byte
         if (kind >= 6) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            text.insert(text.size(),
                        $urandom_range(1) ? 8'($urandom_range(255)) : alphabet_char());
         end
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, 2'd0, 24'h0);
   endtask

   always @(posedge clock) begin : rsp_check
      decoded_type got;
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_data_byte, rsp_byte_valid, rsp_string_done, rsp_run_last};
         if (expected_decoded.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected item: data %h valid %b done %b last %b",
                        got.data, got.byte_ok, got.done, got.last);
            mismatches++;
         end else begin
            want = expected_decoded.pop_front();
            if (got !== want) begin
               if (mismatches < 10)
                  $display({"mismatch: expected data %h valid %b done %b last %b,",
                            " got data %h valid %b done %b last %b"},
                           want.data, want.byte_ok, want.done, want.last,
                           got.data, got.byte_ok, got.done, got.last);
               mismatches++;
            end
         end
      end
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      directed_rows = '{
         '{CHAR_PAD, 1'b1, 1'b1, 2'd0, 24'h0},
         '{8'hff,    1'b1, 1'b1, 2'd0, 24'h0},
         '{8'h00,    1'b1, 1'b1, 2'd0, 24'h0},
         '{"A",      1'b0, 1'b1, 2'd0, 24'h0},
         '{"A",      1'b0, 1'b1, 2'd0, 24'h0},
         '{"A",      1'b0, 1'b1, 2'd0, 24'h0},
         '{"A",      1'b0, 1'b1, 2'd3, 24'h000000},
         '{"/",      1'b0, 1'b1, 2'd0, 24'h0},
         '{"/",      1'b0, 1'b1, 2'd0, 24'h0},
         '{"/",      1'b0, 1'b1, 2'd0, 24'h0},
         '{"/",      1'b1, 1'b1, 2'd3, 24'hffffff},
         '{"/",      1'b0, 1'b1, 2'd0, 24'h0},
         '{"/",      1'b0, 1'b1, 2'd0, 24'h0},
         '{CHAR_PAD, 1'b1, 1'b1, 2'd1, 24'hff0000},
         '{"+",      1'b0, 1'b0, 2'd0, 24'h0},
         '{"9",      1'b0, 1'b0, 2'd0, 24'h0},
         '{"z",      1'b0, 1'b0, 2'd0, 24'h0},
         '{"0",      1'b0, 1'b0, 2'd0, 24'h0},
         '{"a",      1'b0, 1'b0, 2'd0, 24'h0},
         '{"Z",      1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h80,    1'b0, 1'b0, 2'd0, 24'h0},
         '{"Q",      1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h7f,    1'b1, 1'b0, 2'd0, 24'h0},
         '{"T",      1'b0, 1'b0, 2'd0, 24'h0},
         '{"W",      1'b0, 1'b0, 2'd0, 24'h0},
         '{"E",      1'b1, 1'b0, 2'd0, 24'h0}
      };
      held_sextets = '{default: 6'd0};
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].eos, directed_rows[i].typed,
                   directed_rows[i].n_bytes, directed_rows[i].bytes);
      while (chars_sent < 130) send_random_string();

      send_idle_pct = 65;
      recv_idle_pct = 11;
      while (chars_sent < 230) send_random_string();

      // no idling; receiver holds off long enough for the input to back up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 1'b1;
      while (chars_sent < 330) send_random_string();
      req_valid <= 1'b0;

      while (expected_decoded.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
